// ===== rtl/mbrp_pkg.sv =====
// Shared types, codes and the byte-wide CRC-16 update for the Modbus reply parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package mbrp_pkg;

  localparam int DEF_BRANCHES = 32;
  localparam int BITMAP_W     = 32;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Function codes handled
  localparam logic [7:0] FC_READ_COILS = 8'h02;
  localparam logic [7:0] FC_READ_HOLD  = 8'h03;
  localparam logic [7:0] FC_READ_INPUT = 8'h04;
  localparam logic [7:0] FC_WRITE_COIL = 8'h05;

  localparam logic [7:0] COIL_ON_BYTE  = 8'hFF;
  localparam logic [7:0] COIL_OFF_BYTE = 8'h00;
  localparam logic [7:0] CNT_MAX       = 8'hFF;
  localparam logic [7:0] SLAVE_RESET   = 8'h01;

  typedef enum logic [2:0] {
    KIND_SHORT       = 3'd0,
    KIND_CRC_BAD     = 3'd1,
    KIND_OTHER_ADDR  = 3'd2,
    KIND_UNHANDLED   = 3'd3,
    KIND_SWITCH      = 3'd4,
    KIND_CURRENT     = 3'd5,
    KIND_MAX_CURRENT = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] branch;
    logic       on;
    logic [7:0] reading;
  } result_t;

  // One byte through the reflected CRC-16, bit by bit
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mbrp_frame_eval.sv =====
// Frame judgement for the Modbus reply parser: CRC check, address check, function decode
// and branch bitmap update. Purely combinational; depends on mbrp_pkg.
`default_nettype none

module mbrp_frame_eval #(
  parameter int  BRANCHES = mbrp_pkg::DEF_BRANCHES,
  localparam int MapW     = (BRANCHES < 32) ? BRANCHES : 32
) (
  input  logic [15:0]       crc_calc,
  input  logic [15:0]       crc_rx,
  input  logic [5:0][7:0]   hdr,
  input  logic [7:0]        byte_cnt,   // bytes before the last one
  input  logic [7:0]        slave_addr,
  input  logic [7:0]        reply_cnt,
  input  logic [MapW-1:0]   map_cur,
  output mbrp_pkg::result_t res,
  output logic [MapW-1:0]   map_nxt,
  output logic              cnt_bump
);
  import mbrp_pkg::*;

  logic       put;
  logic [7:0] fc;

  assign fc = hdr[1];

  always_comb begin
    res      = '0;
    res.kind = KIND_SHORT;
    put      = 1'b0;
    cnt_bump = 1'b0;
    if (byte_cnt == 8'd0) begin
      res.kind = KIND_SHORT;
    end else if (crc_calc != crc_rx) begin
      res.kind = KIND_CRC_BAD;
    end else if (hdr[0] != slave_addr) begin
      res.kind = KIND_OTHER_ADDR;
    end else begin
      case (fc)
        FC_READ_COILS: begin
          if (byte_cnt >= 8'd3) begin
            res.kind   = KIND_SWITCH;
            res.branch = reply_cnt;
            res.on     = (hdr[3] != 8'h00);
            put        = 1'b1;
            cnt_bump   = (reply_cnt != CNT_MAX);
          end
        end
        FC_WRITE_COIL: begin
          if (byte_cnt < 8'd5) begin
            res.kind = KIND_SHORT;
          end else if (hdr[4] == COIL_ON_BYTE) begin
            res.kind   = KIND_SWITCH;
            res.branch = hdr[3];
            res.on     = 1'b1;
            put        = 1'b1;
          end else if (hdr[5] == COIL_OFF_BYTE) begin
            res.kind   = KIND_SWITCH;
            res.branch = hdr[3];
            put        = 1'b1;
          end else begin
            res.kind = KIND_UNHANDLED;
          end
        end
        FC_READ_HOLD, FC_READ_INPUT: begin
          if (byte_cnt >= 8'd3) begin
            res.kind    = (fc == FC_READ_HOLD) ? KIND_CURRENT : KIND_MAX_CURRENT;
            res.branch  = hdr[3];
            res.reading = hdr[3];
          end
        end
        default: begin
          res.kind = KIND_UNHANDLED;
        end
      endcase
    end
  end

  // Branches past the bitmap match no bit and leave it unchanged
  always_comb begin
    for (int i = 0; i < MapW; i++) begin
      map_nxt[i] = (put && res.branch == 8'(i)) ? res.on : map_cur[i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/modbus_reply_frame_parser.sv =====
// Top level of the Modbus RTU reply parser: input beat register, frame state and result register.
// Depends on mbrp_pkg and mbrp_frame_eval.
//
// Takes one beat per clock: a reply byte (cmd 0) or a counter restart (cmd 1). A beat passes
// an input register, then CRC update and frame judgement; the result of the frame's last byte
// is captured in the result register that drives the out_ port. Sustained rate is one
// byte per cycle, set by the combinational byte-wide CRC XOR network; the input side stalls
// only when a frame end meets a result that is still held by out_stall. port_bits carries
// the branch bitmap (BRANCHES bits, at most 32, zero above) as it stands after the frame.
`default_nettype none

module modbus_reply_frame_parser #(
  parameter int BRANCHES = mbrp_pkg::DEF_BRANCHES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_frame_kind,
  output logic [7:0]  out_branch_index,
  output logic        out_switch_on,
  output logic [7:0]  out_reading,
  output logic [31:0] out_port_bits
);
  import mbrp_pkg::*;

  localparam int MapW = (BRANCHES < 32) ? BRANCHES : 32;

  // input beat register
  logic            in_v_r;
  logic            cmd_r;
  logic [7:0]      byte_r;
  logic            end_r;

  // frame state
  logic [7:0]      slave_r;
  logic [15:0]     crc_r,   crc_nxt;
  logic [7:0]      held0_r, held1_r;
  logic [5:0][7:0] hdr_r,   hdr_nxt;
  logic [7:0]      cnt_r;
  logic [MapW-1:0] map_r,   map_nxt;
  logic [7:0]      rcnt_r;

  // result register
  logic            out_v_r;
  result_t         res_r;
  logic [31:0]     bits_r;

  logic            adv;
  logic            is_byte;
  logic            is_end;
  logic            cnt_bump;
  result_t         res;

  assign is_byte  = in_v_r && !cmd_r;
  assign is_end   = is_byte && end_r;
  // A frame end needs the result slot; everything else always moves on
  assign adv      = in_v_r && (!is_end || !out_v_r || !out_stall);
  assign in_stall = in_v_r && !adv;

  always_comb begin
    crc_nxt = (cnt_r >= 8'd2) ? crc16_byte(crc_r, held0_r) : crc_r;
    hdr_nxt = hdr_r;
    for (int i = 0; i < 6; i++) begin
      if (cnt_r == 8'(i)) begin
        hdr_nxt[i] = byte_r;
      end
    end
  end

  mbrp_frame_eval #(
    .BRANCHES (BRANCHES)
  ) u_eval (
    .crc_calc   (crc_nxt),
    .crc_rx     ({byte_r, held1_r}),
    .hdr        (hdr_nxt),
    .byte_cnt   (cnt_r),
    .slave_addr (slave_r),
    .reply_cnt  (rcnt_r),
    .map_cur    (map_r),
    .res        (res),
    .map_nxt    (map_nxt),
    .cnt_bump   (cnt_bump)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      slave_r <= SLAVE_RESET;
      crc_r   <= CRC_INIT;
      held0_r <= '0;
      held1_r <= '0;
      cnt_r   <= '0;
      map_r   <= '0;
      rcnt_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        slave_r <= cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        in_v_r <= 1'b1;
      end else if (adv) begin
        in_v_r <= 1'b0;
      end
      if (adv && is_end) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
      if (adv && cmd_r) begin
        rcnt_r <= '0;
      end
      if (adv && is_byte) begin
        if (end_r) begin
          // judge, then return the frame state to reset
          crc_r   <= CRC_INIT;
          held0_r <= '0;
          held1_r <= '0;
          cnt_r   <= '0;
          map_r   <= map_nxt;
          if (cnt_bump) begin
            rcnt_r <= rcnt_r + 8'd1;
          end
        end else begin
          crc_r   <= crc_nxt;
          held0_r <= held1_r;
          held1_r <= byte_r;
          if (cnt_r != CNT_MAX) begin
            cnt_r <= cnt_r + 8'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r  <= in_cmd;
      byte_r <= in_data_byte;
      end_r  <= in_frame_end;
    end
    if (adv && is_byte) begin
      hdr_r <= hdr_nxt;
    end
    if (adv && is_end) begin
      res_r  <= res;
      bits_r <= 32'(map_nxt);
    end
  end

  assign out_valid        = out_v_r;
  assign out_frame_kind   = res_r.kind;
  assign out_branch_index = res_r.branch;
  assign out_switch_on    = res_r.on;
  assign out_reading      = res_r.reading;
  assign out_port_bits    = bits_r;

endmodule

`default_nettype wire

// ===== rtl/mbrp_checker.sv =====
// Port-level checks for modbus_reply_frame_parser, attached by the bind at the end.
// Depends on mbrp_pkg for the frame kind codes.
`default_nettype none

module mbrp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_frame_kind,
  input logic [7:0]  out_branch_index,
  input logic        out_switch_on,
  input logic [7:0]  out_reading,
  input logic [31:0] out_port_bits
);
  import mbrp_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_kind)
      && $stable(out_branch_index) && $stable(out_port_bits))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_on_only_switch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_switch_on |-> out_frame_kind == KIND_SWITCH)
    else $error("switch_on set outside a switch-state reply");

  a_reading_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_kind != KIND_CURRENT && out_frame_kind != KIND_MAX_CURRENT
      |-> out_reading == 8'h00)
    else $error("reading set outside a current reply");

  a_reading_branch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_kind == KIND_CURRENT || out_frame_kind == KIND_MAX_CURRENT)
      |-> out_reading == out_branch_index)
    else $error("current reply reading differs from branch");

endmodule

bind modbus_reply_frame_parser mbrp_checker u_mbrp_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for modbus_reply_frame_parser: random framed replies, predicted results.
// Depends on mbrp_pkg for codes and kinds and on the RTL top level; needs nothing else.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbrp_pkg::*;

  localparam int NBR = DEF_BRANCHES;

  typedef struct {
    kind_t       kind;
    logic [7:0]  branch;
    logic        on;
    logic [7:0]  reading;
    logic [31:0] bits;
  } reply_t;

  // Tracks parser state beat by beat and holds the replies still owed by the block
  class reply_board;
    logic [7:0]  slave;
    logic [15:0] crc;
    logic [7:0]  held [2];
    logic [7:0]  hdr [6];
    logic [7:0]  nbytes;
    logic [31:0] bitmap;
    logic [7:0]  poll_cnt;
    reply_t      replies [$];
    int          mismatches;

    function new();
      slave = SLAVE_RESET;
      crc = CRC_INIT;
      held[0] = 8'h00;
      held[1] = 8'h00;
      foreach (hdr[i]) hdr[i] = 8'h00;
      nbytes = 8'h00;
      bitmap = 32'h0;
      poll_cnt = 8'h00;
      mismatches = 0;
    endfunction

    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
    endfunction

    function void set_bit(int idx, logic v);
      if (idx < NBR && idx < 32) bitmap[idx] = v;
    endfunction

    function void parse_beat(logic restart, logic [7:0] d, logic last);
      int         len;
      reply_t     r;
      logic [7:0] fc;
      if (restart) begin
        poll_cnt = 8'h00;
        return;
      end
      // the last two bytes stay out of the CRC until a later byte pushes them through
      if (nbytes >= 2) crc = crc_step(crc, held[0]);
      held[0] = held[1];
      held[1] = d;
      if (nbytes < 6) hdr[nbytes] = d;
      len = int'(nbytes) + 1;
      if (nbytes != CNT_MAX) nbytes++;
      if (!last) return;

      r.kind = KIND_SHORT;
      r.branch = 8'h00;
      r.on = 1'b0;
      r.reading = 8'h00;
      if (len < 2) begin
        r.kind = KIND_SHORT;
      end else if (crc != {held[1], held[0]}) begin
        r.kind = KIND_CRC_BAD;
      end else if (hdr[0] != slave) begin
        r.kind = KIND_OTHER_ADDR;
      end else begin
        fc = hdr[1];
        case (fc)
          FC_READ_COILS: begin
            if (len >= 4) begin
              r.kind = KIND_SWITCH;
              r.branch = poll_cnt;
              r.on = (hdr[3] != 8'h00);
              set_bit(poll_cnt, r.on);
              if (poll_cnt != CNT_MAX) poll_cnt++;
            end
          end
          FC_WRITE_COIL: begin
            if (len >= 6) begin
              if (hdr[4] == COIL_ON_BYTE) begin
                r.kind = KIND_SWITCH;
                r.branch = hdr[3];
                r.on = 1'b1;
                set_bit(hdr[3], 1'b1);
              end else if (hdr[5] == COIL_OFF_BYTE) begin
                r.kind = KIND_SWITCH;
                r.branch = hdr[3];
                set_bit(hdr[3], 1'b0);
              end else begin
                r.kind = KIND_UNHANDLED;
              end
            end
          end
          FC_READ_HOLD, FC_READ_INPUT: begin
            if (len >= 4) begin
              r.kind = (fc == FC_READ_HOLD) ? KIND_CURRENT : KIND_MAX_CURRENT;
              r.branch = hdr[3];
              r.reading = hdr[3];
            end
          end
          default: r.kind = KIND_UNHANDLED;
        endcase
      end
      crc = CRC_INIT;
      held[0] = 8'h00;
      held[1] = 8'h00;
      nbytes = 8'h00;
      r.bits = bitmap;
      replies.push_back(r);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_result(logic [2:0] k, logic [7:0] br, logic on, logic [7:0] rd,
                      logic [31:0] bits);
      reply_t e;
      if (replies.size() == 0) begin
        report_mismatch($sformatf("reply kind %0d with none outstanding", k));
        return;
      end
      e = replies.pop_front();
      if (k !== e.kind)
        report_mismatch($sformatf("frame_kind %0d, predicted %0d", k, e.kind));
      if (br !== e.branch)
        report_mismatch($sformatf("branch_index %0d, predicted %0d", br, e.branch));
      if (on !== e.on)
        report_mismatch($sformatf("switch_on %0b, predicted %0b", on, e.on));
      if (rd !== e.reading)
        report_mismatch($sformatf("reading %0d, predicted %0d", rd, e.reading));
      if (bits !== e.bits)
        report_mismatch($sformatf("port_bits %h, predicted %h", bits, e.bits));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic        in_cmd;
  logic [7:0]  in_data_byte;
  logic        in_frame_end;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_frame_kind;
  logic [7:0]  out_branch_index;
  logic        out_switch_on;
  logic [7:0]  out_reading;
  logic [31:0] out_port_bits;

  reply_board sb = new();

  bit tx_gaps;
  bit rx_gaps;
  bit hold_req;
  int restart_pct;
  int beats_sent;

  modbus_reply_frame_parser uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_data_byte     (in_data_byte),
    .in_frame_end     (in_frame_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_kind   (out_frame_kind),
    .out_branch_index (out_branch_index),
    .out_switch_on    (out_switch_on),
    .out_reading      (out_reading),
    .out_port_bits    (out_port_bits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

  // mostly short, now and then long
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 70) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // result side back-pressure, including the long hold-off on request
  initial begin
    int run;
    int hold_cnt;
    run = 0;
    hold_cnt = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        hold_cnt++;
        if (hold_cnt == 80) begin
          hold_req = 1'b0;
          hold_cnt = 0;
        end
      end else if (!rx_gaps) begin
        out_stall <= 1'b0;
      end else if (run > 0) begin
        out_stall <= 1'b1;
        run--;
      end else begin
        run = gap_len();
        out_stall <= (run > 0);
        if (run > 0) run--;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_result(out_frame_kind, out_branch_index, out_switch_on, out_reading,
                        out_port_bits);
    end
  end

  task automatic send_beat(input logic c, input logic [7:0] d, input logic last);
    int g;
    g = tx_gaps ? gap_len() : 0;
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_cmd <= 1'($urandom);
      in_data_byte <= 8'($urandom);
      in_frame_end <= 1'($urandom);
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_cmd <= c;
    in_data_byte <= d;
    in_frame_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.parse_beat(c, d, last);
    if (!c) beats_sent++;
  endtask

  task automatic idle_in();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // hold the input until every owed reply is back, then let the pipe settle
  task automatic drain();
    idle_in();
    while (sb.replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_slave(input logic [7:0] v);
    drain();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.slave = v;
  endtask

  task automatic send_raw(input logic [7:0] fr [$]);
    foreach (fr[i]) begin
      if ($urandom_range(99) < restart_pct)
        send_beat(1'b1, 8'($urandom), 1'($urandom));
      send_beat(1'b0, fr[i], i == fr.size() - 1);
    end
  endtask

  task automatic send_frame(input logic [7:0] body [$], input bit crc_ok);
    logic [15:0] c;
    logic [7:0]  fr [$];
    c = CRC_INIT;
    foreach (body[i]) c = sb.crc_step(c, body[i]);
    if (!crc_ok) c = c ^ (16'h0001 << $urandom_range(15));
    fr = body;
    fr.push_back(c[7:0]);
    fr.push_back(c[15:8]);
    send_raw(fr);
  endtask

  function automatic logic [7:0] coil_state();
    case ($urandom_range(2))
      0: return 8'h00;
      1: return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic rand_frame();
    logic [7:0] body [$];
    logic [7:0] a;
    logic [7:0] fc;
    int         sel;
    int         pick;
    int         k;
    a = ($urandom_range(9) == 0) ? 8'($urandom) : sb.slave;
    sel = $urandom_range(99);
    pick = $urandom_range(9);
    if (pick < 3) fc = FC_READ_COILS;
    else if (pick < 5) fc = FC_WRITE_COIL;
    else if (pick < 7) fc = FC_READ_HOLD;
    else if (pick < 9) fc = FC_READ_INPUT;
    else fc = 8'($urandom);
    body = '{a, fc};
    case (fc)
      FC_READ_COILS: begin
        body.push_back(8'h01);
        body.push_back(coil_state());
      end
      FC_READ_HOLD, FC_READ_INPUT: begin
        body.push_back(8'h02);
        body.push_back(8'($urandom));
        body.push_back(8'($urandom));
      end
      FC_WRITE_COIL: begin
        body.push_back(8'h00);
        body.push_back(($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(39)));
        case ($urandom_range(3))
          0: begin
            body.push_back(COIL_ON_BYTE);
            body.push_back(COIL_OFF_BYTE);
          end
          1: begin
            body.push_back(COIL_OFF_BYTE);
            body.push_back(COIL_OFF_BYTE);
          end
          2: begin
            body.push_back(COIL_ON_BYTE);
            body.push_back(8'($urandom));
          end
          default: begin
            body.push_back(8'($urandom));
            body.push_back(8'($urandom));
          end
        endcase
      end
      default: begin
        repeat ($urandom_range(4)) body.push_back(8'($urandom));
      end
    endcase
    if (sel < 65) begin
      send_frame(body, $urandom_range(9) != 0);
    end else if (sel < 85) begin
      // cut before the bytes the code needs
      k = $urandom_range(3);
      while (body.size() > k) void'(body.pop_back());
      send_frame(body, 1'b1);
    end else begin
      body.delete();
      repeat ($urandom_range(8, 1)) body.push_back(8'($urandom));
      send_raw(body);
    end
  endtask

  task automatic mixed_run(input int n);
    int target;
    target = beats_sent + n;
    while (beats_sent < target) rand_frame();
  endtask

  // a three-byte frame whose CRC low byte lands on a handled code: too short for it
  task automatic short_code_frames();
    logic [15:0] c;
    for (int v = 0; v < 256; v++) begin
      c = sb.crc_step(CRC_INIT, 8'(v));
      if (c[7:0] >= FC_READ_COILS && c[7:0] <= FC_WRITE_COIL) begin
        write_slave(8'(v));
        send_frame('{8'(v)}, 1'b1);
        send_frame('{8'(v)}, 1'b1);
      end
    end
  endtask

  task automatic long_frame();
    logic [7:0] body [$];
    body = '{sb.slave, FC_WRITE_COIL, 8'h00, 8'($urandom_range(31)), COIL_ON_BYTE,
             COIL_OFF_BYTE};
    repeat (252) body.push_back(8'($urandom));
    send_frame(body, 1'b1);
  endtask

  // push the poll counter past the bitmap and into saturation
  task automatic counter_sweep();
    restart_pct = 0;
    send_beat(1'b1, 8'($urandom), 1'($urandom));
    for (int i = 0; i < 258; i++) begin
      if ($urandom_range(7) == 0)
        send_frame('{sb.slave, FC_READ_COILS, 8'h01, coil_state()}, 1'b1);
      else
        send_frame('{sb.slave, FC_READ_COILS}, 1'b1);
    end
    send_beat(1'b1, 8'($urandom), 1'($urandom));
    repeat (4) send_frame('{sb.slave, FC_READ_COILS, 8'h01, coil_state()}, 1'b1);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'h00;
    in_valid = 1'b0;
    in_cmd = 1'b0;
    in_data_byte = 8'h00;
    in_frame_end = 1'b0;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    hold_req = 1'b0;
    restart_pct = 0;
    beats_sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: one-byte frame, restart, coil on at the top branch, poll,
    // a current reading, an input read at a foreign address, bad CRC on a bare pair
    send_raw('{SLAVE_RESET});
    send_beat(1'b1, 8'hFF, 1'b1);
    send_frame('{SLAVE_RESET, FC_WRITE_COIL, 8'h00, 8'd31, COIL_ON_BYTE, COIL_OFF_BYTE},
               1'b1);
    send_frame('{SLAVE_RESET, FC_READ_COILS}, 1'b1);
    send_frame('{SLAVE_RESET, FC_READ_HOLD}, 1'b1);
    send_frame('{8'h02, FC_READ_INPUT}, 1'b1);
    send_raw('{8'h00, 8'h00});

    restart_pct = 2;
    mixed_run(75);

    write_slave(8'h00);
    hold_req = 1'b1;
    mixed_run(75);

    write_slave(8'hFF);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    mixed_run(75);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;

    short_code_frames();

    write_slave(8'($urandom));
    long_frame();
    counter_sweep();

    write_slave(8'($urandom));
    restart_pct = 2;
    mixed_run(75);

    drain();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.replies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/mbrp_pkg.sv
rtl/mbrp_frame_eval.sv
rtl/modbus_reply_frame_parser.sv
rtl/mbrp_checker.sv
tb/tb.sv
